FILE: sv/ps2_mouse_packet_cursor_tracker_defines.svh
// assertion macros shared by the tracker modules
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

`ifndef ASSERT_OFF

// invariant checked at every edge outside reset
`define ASSERT_ALW(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant violated");

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_ALW(lbl, clk, rst_n, prop)
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/ps2mct_pkg.sv
package ps2mct_pkg;

    localparam int COORD_BITS = 12;
    localparam int REG_BITS   = 13;
    localparam int BOUND_BITS = COORD_BITS + 1;
    // signed room for position plus a nine-bit delta either way
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int CMP_BITS   = (REG_BITS > BOUND_BITS) ? REG_BITS : BOUND_BITS;
    localparam int BOUND_LIM  = 1 << COORD_BITS;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(640);
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(480);

    // header bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_SYNC   = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF  = 6;
    localparam int HDR_Y_OVF  = 7;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [BOUND_BITS-1:0] t_bound;
    typedef logic [REG_BITS-1:0]   t_cfg_val;

    typedef enum logic {
        CFG_WIDTH_BOUND  = 1'b0,
        CFG_HEIGHT_BOUND = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic     wr_en;
        t_cfg_idx index;
        t_cfg_val data;
    } t_cfg_wr;

    typedef struct packed {
        logic       fire;
        logic [7:0] header;
        logic [7:0] x_delta;
        logic [7:0] y_delta;
    } t_packet;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   left;
        logic   right;
        logic   middle;
    } t_result;

    // zero acts as one, anything above the coordinate range saturates
    function automatic t_bound eff_bound(input t_cfg_val b);
        logic [CMP_BITS-1:0] wide;
        begin
            wide = CMP_BITS'(b);
            if (wide == '0) begin
                return t_bound'(1);
            end
            if (wide > CMP_BITS'(BOUND_LIM)) begin
                return t_bound'(BOUND_LIM);
            end
            return t_bound'(wide);
        end
    endfunction

    function automatic t_coord half_bound(input t_cfg_val b);
        t_bound e;
        begin
            e = eff_bound(b);
            return e[BOUND_BITS-1:1];
        end
    endfunction

endpackage

FILE: sv/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse cursor tracker: takes one controller byte per cycle, frames mouse
// bytes into three-byte packets (header with sync bit 3, x delta, y delta) and
// keeps a clamped cursor position inside the programmed width and height
// bounds; keyboard bytes are ignored. Each good packet yields one item with
// the new position and three button bits, in the cycle after its last byte is
// accepted; packets with an overflow bit are dropped. Throughput is one byte
// per cycle, set by the single combinational pass from framer state through
// the add and clamp into the output register; ready drops only while a result
// item sits in that register and is not being taken. Writing a bound
// recenters that axis to half the bound.
module ps2_mouse_packet_cursor_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_from_mouse,
    output logic                        o_valid,
    input  logic                        i_ready,
    output ps2mct_pkg::t_coord          o_cursor_x,
    output ps2mct_pkg::t_coord          o_cursor_y,
    output logic                        o_left_button,
    output logic                        o_right_button,
    output logic                        o_middle_button,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  ps2mct_pkg::t_cfg_val        i_cfg_wdata
);
    import ps2mct_pkg::*;

    logic    accept;
    logic    slot_free;
    t_packet pkt;
    t_cfg_wr cfg;
    t_result res_next;
    t_result res_out;

    always_comb begin
        accept    = i_valid && slot_free;
        o_ready   = slot_free;
        cfg.wr_en = i_cfg_wr_en;
        cfg.index = t_cfg_idx'(i_cfg_index);
        cfg.data  = i_cfg_wdata;
    end

    ps2mct_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data       (i_data_byte),
        .i_from_mouse (i_from_mouse),
        .o_pkt        (pkt)
    );

    ps2mct_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pkt   (pkt),
        .o_res   (res_next)
    );

    ps2mct_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (pkt.fire),
        .i_res   (res_next),
        .i_ready (i_ready),
        .o_free  (slot_free),
        .o_valid (o_valid),
        .o_res   (res_out)
    );

    always_comb begin
        o_cursor_x      = res_out.x;
        o_cursor_y      = res_out.y;
        o_left_button   = res_out.left;
        o_right_button  = res_out.right;
        o_middle_button = res_out.middle;
    end

endmodule

FILE: sv/ps2mct_framer.sv
module ps2mct_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data,
    input  logic                 i_from_mouse,
    output ps2mct_pkg::t_packet  o_pkt
);
    import ps2mct_pkg::*;

    typedef enum logic [1:0] {
        POS_HEADER,
        POS_XDELTA,
        POS_YDELTA
    } t_pos_e;

    t_pos_e     r_pos, n_pos;
    logic [7:0] r_header, n_header;
    logic [7:0] r_xdelta, n_xdelta;

    always_comb begin
        n_pos         = r_pos;
        n_header      = r_header;
        n_xdelta      = r_xdelta;
        o_pkt.fire    = 1'b0;
        o_pkt.header  = r_header;
        o_pkt.x_delta = r_xdelta;
        o_pkt.y_delta = i_data;
        if (i_accept && i_from_mouse) begin
            case (r_pos)
                POS_HEADER: begin
                    // drop bytes without the sync bit so framing recovers
                    if (i_data[HDR_SYNC]) begin
                        n_header = i_data;
                        n_pos    = POS_XDELTA;
                    end
                end
                POS_XDELTA: begin
                    n_xdelta = i_data;
                    n_pos    = POS_YDELTA;
                end
                default: begin
                    n_pos      = POS_HEADER;
                    o_pkt.fire = !(r_header[HDR_X_OVF] || r_header[HDR_Y_OVF]);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HEADER;
            r_header <= '0;
            r_xdelta <= '0;
        end else begin
            r_pos    <= n_pos;
            r_header <= n_header;
            r_xdelta <= n_xdelta;
        end
    end

endmodule

FILE: sv/ps2mct_cursor.sv
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2mct_cursor (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ps2mct_pkg::t_cfg_wr  i_cfg,
    input  ps2mct_pkg::t_packet  i_pkt,
    output ps2mct_pkg::t_result  o_res
);
    import ps2mct_pkg::*;

    t_cfg_val r_width, n_width;
    t_cfg_val r_height, n_height;
    t_coord   r_pos_x, n_pos_x;
    t_coord   r_pos_y, n_pos_y;

    t_bound                      bound_x;
    t_bound                      bound_y;
    logic signed [8:0]           dx9;
    logic signed [8:0]           dy9;
    logic signed [SUM_BITS-1:0]  sum_x;
    logic signed [SUM_BITS-1:0]  sum_y;
    t_coord                      clamp_x;
    t_coord                      clamp_y;

    function automatic t_coord clamp(input logic signed [SUM_BITS-1:0] v, input t_bound b);
        t_bound bm1;
        begin
            bm1 = b - t_bound'(1);
            if (v[SUM_BITS-1]) begin
                return '0;
            end
            if (v >= $signed({{(SUM_BITS-BOUND_BITS){1'b0}}, b})) begin
                return bm1[COORD_BITS-1:0];
            end
            return v[COORD_BITS-1:0];
        end
    endfunction

    always_comb begin
        bound_x = eff_bound(r_width);
        bound_y = eff_bound(r_height);
        dx9     = {i_pkt.header[HDR_X_SIGN], i_pkt.x_delta};
        dy9     = {i_pkt.header[HDR_Y_SIGN], i_pkt.y_delta};
        sum_x   = $signed({2'b00, r_pos_x}) + {{(SUM_BITS-9){dx9[8]}}, dx9};
        // screen y runs downward, mouse y upward
        sum_y   = $signed({2'b00, r_pos_y}) - {{(SUM_BITS-9){dy9[8]}}, dy9};
        clamp_x = clamp(sum_x, bound_x);
        clamp_y = clamp(sum_y, bound_y);
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        if (i_pkt.fire) begin
            n_pos_x = clamp_x;
            n_pos_y = clamp_y;
        end
        // a bound write recenters that axis
        if (i_cfg.wr_en) begin
            case (i_cfg.index)
                CFG_WIDTH_BOUND: begin
                    n_width = i_cfg.data;
                    n_pos_x = half_bound(i_cfg.data);
                end
                CFG_HEIGHT_BOUND: begin
                    n_height = i_cfg.data;
                    n_pos_y  = half_bound(i_cfg.data);
                end
                default: begin
                    n_width = r_width;
                end
            endcase
        end
    end

    always_comb begin
        o_res.x      = clamp_x;
        o_res.y      = clamp_y;
        o_res.left   = i_pkt.header[HDR_LEFT];
        o_res.right  = i_pkt.header[HDR_RIGHT];
        o_res.middle = i_pkt.header[HDR_MIDDLE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_pos_x  <= half_bound(WIDTH_RESET);
            r_pos_y  <= half_bound(HEIGHT_RESET);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
        end
    end

    `ASSERT_ALW(a_pos_in_bounds, i_clk, i_rst_n,
        ({1'b0, r_pos_x} < eff_bound(r_width)) && ({1'b0, r_pos_y} < eff_bound(r_height)))
    `ASSERT_NXT(a_recenter_x, i_clk, i_rst_n,
        i_cfg.wr_en && (i_cfg.index == CFG_WIDTH_BOUND), r_pos_x == half_bound(r_width))
    `ASSERT_NXT(a_recenter_y, i_clk, i_rst_n,
        i_cfg.wr_en && (i_cfg.index == CFG_HEIGHT_BOUND), r_pos_y == half_bound(r_height))

endmodule

FILE: sv/ps2mct_result_reg.sv
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module ps2mct_result_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ps2mct_pkg::t_result  i_res,
    input  logic                 i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output ps2mct_pkg::t_result  o_res
);
    import ps2mct_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        o_free  = !r_valid || i_ready;
        n_valid = i_load || (r_valid && !i_ready);
        o_valid = r_valid;
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    `ASSERT_IMP(a_load_into_free_slot, i_clk, i_rst_n, i_load, o_free)

endmodule
